// File: src/assert_macros.svh
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define BBA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rstn, prop, msg)
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: src/bba_pkg.sv
// types, codes and constants of the bitmap block allocator
package bba_pkg;

	// fixed field widths
	localparam int CMD_W      = 2;
	localparam int OFFSET_W   = 12;
	localparam int SLOT_OUT_W = 10;
	localparam int STATUS_W   = 2;
	localparam int FREE_OUT_W = 11;
	localparam int CFG_W      = 9;

	// bitmap geometry
	localparam int WORD_BITS = 64;
	localparam int BIT_W     = 6;
	localparam logic [WORD_BITS-1:0] WORD_MSB = {1'b1, {(WORD_BITS-1){1'b0}}};

	// block size limits
	localparam logic [CFG_W-1:0] BLK_MIN   = 9'd4;
	localparam logic [CFG_W-1:0] BLK_MAX   = 9'd256;
	localparam logic [CFG_W-1:0] BLK_RESET = 9'd4;

	// parameter defaults
	localparam int DEF_PAGE_BYTES = 4096;
	localparam int DEF_MAX_WORDS  = 16;
	localparam int DEF_DVD_W      = 13;

	// commands
	localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_DONE         = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL         = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ALREADY_FREE = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE        = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_INIT_WR,
		S_SCAN,
		S_FBYTE,
		S_FBIT,
		S_MUL,
		S_FR_RD,
		S_FR_UPD,
		S_OUT
	} bba_state_t;

endpackage

// File: src/bba_div.sv
// serial restoring divider, one quotient bit per cycle
module bba_div import bba_pkg::*; #(
	parameter int DVD_W = DEF_DVD_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [CFG_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] dsr_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [CFG_W:0]   trial;
	logic [CFG_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dsr_q  <= BLK_RESET;
			quo_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				rem_q <= '0;
				dsr_q <= divisor;
				quo_q <= dividend;
				cnt_q <= CNT_W'(DVD_W);
			end else if (cnt_q != '0) begin
				rem_q <= ge ? CFG_W'(diff) : CFG_W'(trial);
				quo_q <= {quo_q[DVD_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: src/bitmap_block_allocator.sv
// top level of the bitmap block allocator
//
// channel   direction  handshake                  payload
// config    in         cfg_we, no wait            cfg_data (block size in bytes)
// command   in         start && !busy             command, offset
// result    out        done, one cycle strobe     block_offset, slot_index, status, free_left
//
// one item at a time; busy stays high from the accepting edge until the result strobe
// init: serial divide (one bit a cycle) plus one bitmap word write a cycle
// allocate: scan reading one bitmap word a cycle, then byte search, bit search and multiply
// free: serial divide of the offset, one read and, unless already free, one write of a bitmap word
// asynchronous reset clears all control state; the bitmap is undefined until an init
// the result is shown for one cycle and cannot be stalled; start is taken the cycle after

`include "assert_macros.svh"

module bitmap_block_allocator import bba_pkg::*; #(
	parameter int PAGE_BYTES = DEF_PAGE_BYTES,
	parameter int MAX_WORDS  = DEF_MAX_WORDS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  start,
	input  logic [CMD_W-1:0]      command,
	input  logic [OFFSET_W-1:0]   offset,
	output logic                  busy,
	output logic                  done,
	output logic [OFFSET_W-1:0]   block_offset,
	output logic [SLOT_OUT_W-1:0] slot_index,
	output logic [STATUS_W-1:0]   status,
	output logic [FREE_OUT_W-1:0] free_left
);

	// derived sizes
	localparam int WORD_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int WIU_W      = $clog2(MAX_WORDS + 1);
	localparam int TOT_W      = WIU_W + BIT_W;
	localparam int SLOT_W     = WORD_W + BIT_W;
	localparam int PG_W       = $clog2(PAGE_BYTES + 1);
	localparam int DVD_W      = (PG_W > OFFSET_W) ? PG_W : OFFSET_W;
	localparam int CMP_W      = (DVD_W > TOT_W) ? DVD_W : TOT_W;
	localparam int MUL_W      = SLOT_W + CFG_W;
	localparam int MAX_BLOCKS = MAX_WORDS * WORD_BITS;

	bba_state_t state_q, nxt_state;

	// config and page state
	logic [CFG_W-1:0]     blk_cfg_q;
	logic [CFG_W-1:0]     live_b_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [TOT_W-1:0]     total_q;
	logic [TOT_W-1:0]     free_q;
	logic [WIU_W-1:0]     wiu_q;
	logic [WIU_W-1:0]     full_q;
	logic [BIT_W-1:0]     part_q;
	logic [WORD_W-1:0]    cursor_q;

	// sequencer working registers
	logic [WORD_W-1:0]    w_q;
	logic [WORD_W-1:0]    scan_w_q;
	logic [WORD_W-1:0]    chk_w_q;
	logic                 chk_vld_q;
	logic [WIU_W-1:0]     n_q;
	logic [WORD_BITS-1:0] word_q;
	logic [WORD_W-1:0]    found_w_q;
	logic [2:0]           byte_q;
	logic [SLOT_W-1:0]    slot_q;

	// result registers
	logic [OFFSET_W-1:0]   res_off_q;
	logic [SLOT_OUT_W-1:0] res_slot_q;
	logic [STATUS_W-1:0]   res_status_q;

	// bitmap memory
	logic [WORD_BITS-1:0] mem [MAX_WORDS];
	logic [WORD_BITS-1:0] rd_q;
	logic                 mem_we;
	logic [WORD_W-1:0]    mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [WORD_W-1:0]    mem_raddr;

	// combinational helpers
	logic                 accept;
	logic [CFG_W-1:0]     blk_sat;
	logic                 div_start;
	logic [DVD_W-1:0]     div_dividend;
	logic [CFG_W-1:0]     div_divisor;
	logic                 div_done;
	logic [DVD_W-1:0]     div_quo;
	logic [CMP_W-1:0]     quo_ext;
	logic                 out_of_range;
	logic [TOT_W-1:0]     clamp_tot;
	logic [WIU_W-1:0]     full_new;
	logic [BIT_W-1:0]     part_new;
	logic [WIU_W-1:0]     wiu_new;
	logic                 alloc_ok;
	logic [WORD_W-1:0]    start_w;
	logic [WIU_W-1:0]     scan_inc;
	logic [WORD_W-1:0]    scan_nxt;
	logic                 scan_last;
	logic                 init_last;
	logic                 rd_full;
	logic [2:0]           byte_sel;
	logic [7:0]           sel_byte;
	logic [2:0]           bit_sel;
	logic [BIT_W-1:0]     bit_j;
	logic [WORD_BITS-1:0] alloc_mask;
	logic [WORD_BITS-1:0] fr_mask;
	logic [WORD_BITS-1:0] init_pat;
	logic [MUL_W-1:0]     prod;

	assign accept = start && !busy;

	// block size saturated into the legal range
	always_comb begin
		if (blk_cfg_q < BLK_MIN) begin
			blk_sat = BLK_MIN;
		end else if (blk_cfg_q > BLK_MAX) begin
			blk_sat = BLK_MAX;
		end else begin
			blk_sat = blk_cfg_q;
		end
	end

	// shared divider: page size / block size at init, offset / block size at free
	assign div_dividend = (command == CMD_INIT) ? DVD_W'(PAGE_BYTES) : DVD_W'(offset);
	assign div_divisor  = (command == CMD_INIT) ? blk_sat : live_b_q;

	bba_div #(
		.DVD_W(DVD_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quo)
	);

	// block count clamped to the bitmap, split into full words and a partial word
	assign quo_ext      = CMP_W'(div_quo);
	assign out_of_range = quo_ext >= CMP_W'(total_q);
	assign clamp_tot    = (quo_ext > CMP_W'(MAX_BLOCKS)) ? TOT_W'(MAX_BLOCKS) : TOT_W'(div_quo);
	assign full_new     = clamp_tot[TOT_W-1:BIT_W];
	assign part_new     = clamp_tot[BIT_W-1:0];
	assign wiu_new      = full_new + WIU_W'(part_new != '0);

	// pad bits of the partial word read as used
	assign init_pat = (WIU_W'(w_q) < full_q) ? '0 : ({WORD_BITS{1'b1}} >> part_q);
	assign init_last = (WIU_W'(w_q) + WIU_W'(1)) == wiu_q;

	// scan bookkeeping, wrapping at the words in use
	assign alloc_ok  = (free_q != '0) && (wiu_q != '0);
	assign start_w   = (WIU_W'(cursor_q) >= wiu_q) ? '0 : cursor_q;
	assign scan_inc  = WIU_W'(scan_w_q) + WIU_W'(1);
	assign scan_nxt  = (scan_inc >= wiu_q) ? '0 : WORD_W'(scan_inc);
	assign scan_last = (n_q + WIU_W'(1)) == wiu_q;
	assign rd_full   = &rd_q;

	// first byte with a free slot, msb side first
	always_comb begin
		logic fnd;
		fnd      = 1'b0;
		byte_sel = '0;
		for (int i = 0; i < 8; i++) begin
			if (!fnd && (word_q[WORD_BITS-1-8*i -: 8] != 8'hFF)) begin
				byte_sel = 3'(i);
				fnd      = 1'b1;
			end
		end
	end

	// first free bit of the chosen byte
	assign sel_byte = 8'(word_q >> {3'(3'd7 - byte_q), 3'b000});

	always_comb begin
		logic fnd;
		fnd     = 1'b0;
		bit_sel = '0;
		for (int i = 0; i < 8; i++) begin
			if (!fnd && !sel_byte[7-i]) begin
				bit_sel = 3'(i);
				fnd     = 1'b1;
			end
		end
	end

	assign bit_j      = {byte_q, bit_sel};
	assign alloc_mask = WORD_MSB >> bit_j;
	assign fr_mask    = WORD_MSB >> slot_q[BIT_W-1:0];

	// byte offset of the allocated slot
	assign prod = MUL_W'(slot_q) * MUL_W'(live_b_q);

	// next state
	always_comb begin
		nxt_state = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority case (command)
						CMD_INIT, CMD_FREE: nxt_state = S_DIV;
						CMD_ALLOC:          nxt_state = alloc_ok ? S_SCAN : S_OUT;
						default:            nxt_state = S_OUT;
					endcase
				end
			end
			S_DIV: begin
				if (div_done) begin
					if (cmd_q == CMD_INIT) begin
						nxt_state = (wiu_new != '0) ? S_INIT_WR : S_OUT;
					end else begin
						nxt_state = out_of_range ? S_OUT : S_FR_RD;
					end
				end
			end
			S_INIT_WR: begin
				if (init_last) begin
					nxt_state = S_OUT;
				end
			end
			S_SCAN: begin
				if (chk_vld_q) begin
					if (!rd_full) begin
						nxt_state = S_FBYTE;
					end else if (scan_last) begin
						nxt_state = S_OUT;
					end
				end
			end
			S_FBYTE:  nxt_state = S_FBIT;
			S_FBIT:   nxt_state = S_MUL;
			S_MUL:    nxt_state = S_OUT;
			S_FR_RD:  nxt_state = S_FR_UPD;
			S_FR_UPD: nxt_state = S_OUT;
			S_OUT:    nxt_state = S_IDLE;
			default:  nxt_state = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy      = (state_q != S_IDLE);
		done      = (state_q == S_OUT);
		div_start = accept && ((command == CMD_INIT) || (command == CMD_FREE));
		mem_we    = 1'b0;
		mem_waddr = w_q;
		mem_wdata = init_pat;
		mem_raddr = (state_q == S_SCAN) ? scan_w_q : slot_q[SLOT_W-1:BIT_W];
		unique case (state_q)
			S_INIT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = w_q;
				mem_wdata = init_pat;
			end
			S_FBIT: begin
				mem_we    = 1'b1;
				mem_waddr = found_w_q;
				mem_wdata = word_q | alloc_mask;
			end
			S_FR_UPD: begin
				mem_we    = (rd_q & fr_mask) != '0;
				mem_waddr = slot_q[SLOT_W-1:BIT_W];
				mem_wdata = rd_q & ~fr_mask;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// bitmap words, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[mem_raddr];
	end

	// state and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			blk_cfg_q    <= BLK_RESET;
			live_b_q     <= BLK_RESET;
			cmd_q        <= CMD_INIT;
			total_q      <= '0;
			free_q       <= '0;
			wiu_q        <= '0;
			full_q       <= '0;
			part_q       <= '0;
			cursor_q     <= '0;
			w_q          <= '0;
			scan_w_q     <= '0;
			chk_w_q      <= '0;
			chk_vld_q    <= 1'b0;
			n_q          <= '0;
			word_q       <= '0;
			found_w_q    <= '0;
			byte_q       <= '0;
			slot_q       <= '0;
			res_off_q    <= '0;
			res_slot_q   <= '0;
			res_status_q <= STAT_DONE;
		end else begin
			state_q <= nxt_state;
			if (cfg_we) begin
				blk_cfg_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q        <= command;
						res_off_q    <= '0;
						res_slot_q   <= '0;
						res_status_q <= STAT_DONE;
						if (command == CMD_INIT) begin
							live_b_q <= blk_sat;
						end
						if (command == CMD_ALLOC) begin
							scan_w_q  <= start_w;
							chk_vld_q <= 1'b0;
							n_q       <= '0;
							if (!alloc_ok) begin
								res_status_q <= STAT_FULL;
							end
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (cmd_q == CMD_INIT) begin
							total_q  <= clamp_tot;
							free_q   <= clamp_tot;
							wiu_q    <= wiu_new;
							full_q   <= full_new;
							part_q   <= part_new;
							cursor_q <= '0;
							w_q      <= '0;
						end else begin
							res_slot_q <= SLOT_OUT_W'(div_quo);
							slot_q     <= SLOT_W'(div_quo);
							if (out_of_range) begin
								res_status_q <= STAT_RANGE;
							end
						end
					end
				end
				S_INIT_WR: begin
					w_q <= WORD_W'(WIU_W'(w_q) + WIU_W'(1));
				end
				S_SCAN: begin
					// one word issued and one word checked each cycle
					scan_w_q  <= scan_nxt;
					chk_w_q   <= scan_w_q;
					chk_vld_q <= 1'b1;
					if (chk_vld_q) begin
						if (!rd_full) begin
							word_q    <= rd_q;
							found_w_q <= chk_w_q;
						end else begin
							n_q <= n_q + WIU_W'(1);
							if (scan_last) begin
								res_status_q <= STAT_FULL;
							end
						end
					end
				end
				S_FBYTE: begin
					byte_q <= byte_sel;
				end
				S_FBIT: begin
					slot_q   <= {found_w_q, bit_j};
					cursor_q <= found_w_q;
					free_q   <= free_q - TOT_W'(1);
				end
				S_MUL: begin
					res_off_q  <= OFFSET_W'(prod);
					res_slot_q <= SLOT_OUT_W'(slot_q);
				end
				S_FR_UPD: begin
					if ((rd_q & fr_mask) == '0) begin
						res_status_q <= STAT_ALREADY_FREE;
					end else begin
						free_q <= free_q + TOT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign block_offset = res_off_q;
	assign slot_index   = res_slot_q;
	assign status       = res_status_q;
	assign free_left    = FREE_OUT_W'(free_q);

	// result strobe lasts one cycle
	`BBA_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result strobe held past one cycle")
	// an accepted item keeps the block busy
	`BBA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted item not busy")
	// free count never passes the block count
	`BBA_ASSERT(a_free_le_total, clk, arst_n, free_q <= total_q, "free count above block count")
	// scan cursor stays inside the words in use
	`BBA_ASSERT(a_cursor_range, clk, arst_n, (wiu_q == '0) || (WIU_W'(cursor_q) < wiu_q),
		"scan cursor beyond words in use")

endmodule
